/* hw/rtl/hmtd_pkg.sv */
// shared types and constants of the code-tree table decoder
`timescale 1ns / 1ps
package hmtd_pkg;

  localparam int TABLE_WORDS = 512;
  localparam int ADDR_W      = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int OFF_LIMIT   = 2 * TABLE_WORDS;
  localparam int NODE_W      = 16;
  localparam int IDX_W       = 9;
  localparam int CODE_BITS   = 16;
  localparam int CNT_W       = $clog2(CODE_BITS + 1);
  localparam int LEAF_BIT    = 15;
  localparam int SYM_W       = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [NODE_W-1:0] data;
  } qitem_t;

endpackage

/* hw/rtl/hmtd_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module hmtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/hmtd_front.sv */
// input beat classification and two-entry command queue
`timescale 1ns / 1ps
module hmtd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [47:0]     in_tdata,
  input  logic            in_tuser,
  output logic            head_valid,
  output hmtd_pkg::qitem_t head,
  input  logic            take
);
  import hmtd_pkg::*;

  logic [IDX_W-1:0]  table_index;
  logic [NODE_W-1:0] table_word;
  logic [NODE_W-1:0] code_word;
  logic [31:0]       idx_ext;
  qitem_t            item;
  qitem_t            mem_r [QUEUE_DEPTH];
  logic              wptr_r, wptr_nxt;
  logic              rptr_r, rptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              push, pop;

  assign table_index = in_tdata[8:0];
  assign table_word  = in_tdata[24:9];
  assign code_word   = in_tdata[40:25];
  assign idx_ext     = 32'(table_index);

  always_comb begin
    item.addr = idx_ext[ADDR_W-1:0];
    if (in_tuser) begin
      item.op   = OP_DECODE;
      item.data = code_word;
    end else begin
      item.op   = (idx_ext < 32'(TABLE_WORDS)) ? OP_WRITE : OP_NOP;
      item.data = table_word;
    end
  end

  assign in_tready  = (count_r != 2'(QUEUE_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign head_valid = (count_r != 2'd0);
  assign pop        = take && head_valid;
  assign head       = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= item;
    end
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/hmtd_back.sv */
// table store, tree walk over code bits and result output stage
`timescale 1ns / 1ps
module hmtd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  hmtd_pkg::qitem_t head,
  output logic             take,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import hmtd_pkg::*;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              err_r, err_nxt;
  logic [NODE_W-1:0] off_r, off_nxt;
  logic [NODE_W-1:0] code_r, code_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [SYM_W-1:0]  hold_byte_r, hold_byte_nxt;
  logic              hold_err_r, hold_err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_byte_r, out_byte_nxt;
  logic              out_err_r, out_err_nxt;
  logic              out_last_r, out_last_nxt;

  logic              we, re;
  logic [ADDR_W-1:0] raddr;
  logic [NODE_W-1:0] rdata;

  logic              new_res, flush, push, push_last, out_free, stall;
  logic [NODE_W-1:0] base, off_step;

  hmtd_ram #(
    .WIDTH(NODE_W),
    .DEPTH(TABLE_WORDS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(head.addr),
    .wdata(head.data),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign new_res   = pend_r && (err_r || rdata[LEAF_BIT]);
  assign base      = pend_r ? (new_res ? '0 : rdata) : off_r;
  assign off_step  = base + (code_r[CODE_BITS-1] ? NODE_W'(2) : NODE_W'(0));
  assign flush     = busy_r && (cnt_r == CNT_W'(CODE_BITS)) && !pend_r;
  assign push      = busy_r && (flush ? hold_v_r : (new_res && hold_v_r));
  assign push_last = flush;
  assign out_free  = !out_valid_r || out_tready;
  assign stall     = push && !out_free;
  assign raddr     = off_step[ADDR_W:1];

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    off_nxt       = off_r;
    code_nxt      = code_r;
    hold_v_nxt    = hold_v_r;
    hold_byte_nxt = hold_byte_r;
    hold_err_nxt  = hold_err_r;
    take          = 1'b0;
    we            = 1'b0;
    re            = 1'b0;

    if (!busy_r) begin
      if (head_valid) begin
        take = 1'b1;
        unique case (head.op)
          OP_WRITE: begin
            we = 1'b1;
          end
          OP_DECODE: begin
            busy_nxt = 1'b1;
            cnt_nxt  = '0;
            pend_nxt = 1'b0;
            code_nxt = head.data;
          end
          default: begin
          end
        endcase
      end
    end else if (!stall) begin
      if (flush) begin
        busy_nxt   = 1'b0;
        hold_v_nxt = 1'b0;
      end else begin
        if (new_res) begin
          hold_v_nxt    = 1'b1;
          hold_err_nxt  = err_r;
          hold_byte_nxt = err_r ? '0 : rdata[SYM_W-1:0];
        end
        if (cnt_r != CNT_W'(CODE_BITS)) begin
          err_nxt  = (32'(off_step) >= 32'(OFF_LIMIT));
          re       = !err_nxt;
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
          code_nxt = {code_r[CODE_BITS-2:0], 1'b0};
        end else begin
          pend_nxt = 1'b0;
          off_nxt  = base;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    if (push && out_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hold_byte_r;
      out_err_nxt   = hold_err_r;
      out_last_nxt  = push_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    err_r       <= err_nxt;
    code_r      <= code_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_err_r  <= hold_err_nxt;
    out_byte_r  <= out_byte_nxt;
    out_err_r   <= out_err_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      off_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      off_r       <= off_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/huffman_table_tree_decoder_core.sv */
// top level of the code-tree table decoder: command queue front, tree walk back
// a table load beat is taken and written to the table; a code word beat is taken, then
// walked with one dependent registered table read per code bit; the last read is resolved
// and the word is closed, the held result leaving with tlast; a result is held until the
// next result or the close; output stalls hold the walk
// reset clears the queue, walk offset and output stage; table words are undefined until loaded
`timescale 1ns / 1ps
module huffman_table_tree_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // table_index, table_word, code_word, zero pad
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tuser,  // error
  output logic        out_tlast
);
  import hmtd_pkg::*;

  logic   head_valid;
  qitem_t head;
  logic   take;

  hmtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head_valid(head_valid),
    .head      (head),
    .take      (take)
  );

  hmtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .take      (take),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
